// File: design/pvr_pkg.sv
// ----------------------------------------------------------------------------
// pvr_pkg
// Shared widths, reset values, register codes, config struct and beat type of the
// velocity regulator.
// ----------------------------------------------------------------------------
package pvr_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned GainW  = 24;
  localparam int unsigned LimitW = 31;
  localparam int unsigned ErrW   = 33;
  localparam int unsigned DiffW  = 34;
  localparam int unsigned AccW   = 34;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned FracBits = 16;

  localparam logic [GainW-1:0]  GainPReset = 24'd6554;
  localparam logic [GainW-1:0]  GainIReset = 24'd655;
  localparam logic [GainW-1:0]  GainDReset = 24'd0;
  localparam logic [LimitW-1:0] LimitReset = 31'd65536000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P    = 2'd0,
    REG_GAIN_I    = 2'd1,
    REG_GAIN_D    = 2'd2,
    REG_INT_LIMIT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [GainW-1:0]  kp;
    logic [GainW-1:0]  ki;
    logic [GainW-1:0]  kd;
    logic [LimitW-1:0] limit;
  } cfg_t;

  // Beat passed from the integrator to the multiply/accumulate section.
  typedef struct packed {
    logic signed [ErrW-1:0]   err;
    logic signed [DiffW-1:0]  diff;
    logic signed [ValueW-1:0] integ;
  } mid_beat_t;

endpackage

// File: design/pvr_if.sv
// ----------------------------------------------------------------------------
// pvr_in_if / pvr_out_if
// Valid/ready stream interfaces for sample beats and drive beats.
// ----------------------------------------------------------------------------
interface pvr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pvr_pkg::ValueW-1:0]   target_value;
  logic signed [pvr_pkg::ValueW-1:0]   measured_value;
  logic                                integral_clear;
  logic                                integral_hold;

  modport source (output valid, target_value, measured_value, integral_clear,
                  integral_hold, input ready);
  modport sink   (input valid, target_value, measured_value, integral_clear,
                  integral_hold, output ready);
endinterface

interface pvr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pvr_pkg::ValueW-1:0]   drive_value;

  modport source (output valid, drive_value, input ready);
  modport sink   (input valid, drive_value, output ready);
endinterface

// File: design/pid_velocity_regulator.sv
// ----------------------------------------------------------------------------
// pid_velocity_regulator
// PID velocity controller with a clamped integral, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage: each beat on in_stream carries a target and a measured velocity plus
// the integral clear and hold flags; each produces one drive beat on
// out_stream. Gains and the integral limit are written through the cfg_ port
// (index 0 to 3: kp, ki, kd, limit) while no beat is in flight.
// Pipeline: a sample beat passes the error register, the integral stage, the
// product register and the output register, the first loaded at the accepting
// edge. Throughput: one beat per cycle while out_stream.ready is high; the
// integral loop closes within the single integral stage, so back-to-back
// samples need no spacing.
// Reset: rst_n clears the integral, the previous error and all valid flags,
// and loads the default gains and limit.
// Stall: when out_stream.ready is low the output register holds its beat and
// the earlier stages keep filling until each holds a beat; then in_stream
// drops ready.
// ----------------------------------------------------------------------------
module pid_velocity_regulator (
  input  logic                             clk,
  input  logic                             rst_n,
  pvr_in_if.sink                           in_stream,
  pvr_out_if.source                        out_stream,
  input  logic                             cfg_we,
  input  logic [pvr_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [pvr_pkg::CfgDataW-1:0]     cfg_wdata
);

  pvr_pkg::cfg_t       cfg_r;
  logic                mid_valid;
  logic                mid_ready;
  pvr_pkg::mid_beat_t  mid_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp <= pvr_pkg::GainPReset;
      cfg_r.ki <= pvr_pkg::GainIReset;
      cfg_r.kd <= pvr_pkg::GainDReset;
      cfg_r.limit <= pvr_pkg::LimitReset;
    end else if (cfg_we) begin
      case (pvr_pkg::cfg_reg_t'(cfg_index))
        pvr_pkg::REG_GAIN_P:    cfg_r.kp <= cfg_wdata[pvr_pkg::GainW-1:0];
        pvr_pkg::REG_GAIN_I:    cfg_r.ki <= cfg_wdata[pvr_pkg::GainW-1:0];
        pvr_pkg::REG_GAIN_D:    cfg_r.kd <= cfg_wdata[pvr_pkg::GainW-1:0];
        pvr_pkg::REG_INT_LIMIT: cfg_r.limit <= cfg_wdata[pvr_pkg::LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  pvr_integrator u_integrator (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .limit     (cfg_r.limit),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_beat  (mid_beat)
  );

  pvr_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .mid_valid  (mid_valid),
    .mid_ready  (mid_ready),
    .mid_beat   (mid_beat),
    .out_stream (out_stream)
  );

`ifndef SYNTHESIS
  // No drive beat can appear right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_stream.valid)
    else $error("drive beat valid right after reset");

  // The integral handed downstream stays inside the configured clamp.
  a_integral_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    mid_valid |-> ($signed({{2{mid_beat.integ[pvr_pkg::ValueW-1]}}, mid_beat.integ})
                   <= $signed({3'b000, cfg_r.limit}))
              && ($signed({{2{mid_beat.integ[pvr_pkg::ValueW-1]}}, mid_beat.integ})
                   >= -$signed({3'b000, cfg_r.limit})))
    else $error("integral outside the configured limit");

  // The product stage only backs up when a drive beat is being held.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !mid_ready |-> (out_stream.valid && !out_stream.ready))
    else $error("product stage stalled without a held drive beat");
`endif

endmodule

// File: design/pvr_integrator.sv
// ----------------------------------------------------------------------------
// pvr_integrator
// Error register, then the clamped integral and the error difference.
// ----------------------------------------------------------------------------
module pvr_integrator (
  input  logic                               clk,
  input  logic                               rst_n,
  pvr_in_if.sink                             in_stream,
  input  logic [pvr_pkg::LimitW-1:0]         limit,
  output logic                               mid_valid,
  input  logic                               mid_ready,
  output pvr_pkg::mid_beat_t                 mid_beat
);

  logic                                  v1_r;
  logic signed [pvr_pkg::ErrW-1:0]       err1_r;
  logic                                  clear1_r;
  logic                                  hold1_r;
  logic                                  v2_r;
  pvr_pkg::mid_beat_t                    beat2_r;
  logic signed [pvr_pkg::ValueW-1:0]     integral_sum_r;
  logic signed [pvr_pkg::ErrW-1:0]       last_error_r;

  logic                                  en1;
  logic                                  en2;
  logic signed [pvr_pkg::ErrW-1:0]       err_nxt;
  logic signed [pvr_pkg::AccW-1:0]       acc;
  logic signed [pvr_pkg::AccW-1:0]       lim_pos;
  logic signed [pvr_pkg::AccW-1:0]       lim_neg;
  logic signed [pvr_pkg::ValueW-1:0]     integral_sum_nxt;
  logic signed [pvr_pkg::DiffW-1:0]      diff_nxt;

  assign en2 = !v2_r || mid_ready;
  assign en1 = !v1_r || en2;
  assign in_stream.ready = en1;

  assign err_nxt = $signed({in_stream.target_value[pvr_pkg::ValueW-1],
                            in_stream.target_value})
                 - $signed({in_stream.measured_value[pvr_pkg::ValueW-1],
                            in_stream.measured_value});

  always_comb begin
    lim_pos = $signed({3'b000, limit});
    lim_neg = -lim_pos;
    acc = {{(pvr_pkg::AccW-pvr_pkg::ValueW){integral_sum_r[pvr_pkg::ValueW-1]}},
           integral_sum_r};
    if (!hold1_r) begin
      acc = acc + {err1_r[pvr_pkg::ErrW-1], err1_r};
    end
    if (clear1_r) begin
      acc = '0;
    end
    if (acc > lim_pos) begin
      acc = lim_pos;
    end else if (acc < lim_neg) begin
      acc = lim_neg;
    end
    // The clamp keeps the sum inside 32 bits.
    integral_sum_nxt = acc[pvr_pkg::ValueW-1:0];
    diff_nxt = {err1_r[pvr_pkg::ErrW-1], err1_r}
             - {last_error_r[pvr_pkg::ErrW-1], last_error_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      integral_sum_r <= '0;
      last_error_r <= '0;
    end else begin
      if (en1) begin
        v1_r <= in_stream.valid;
      end
      if (en2) begin
        v2_r <= v1_r;
        if (v1_r) begin
          integral_sum_r <= integral_sum_nxt;
          last_error_r <= err1_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_stream.valid) begin
      err1_r <= err_nxt;
      clear1_r <= in_stream.integral_clear;
      hold1_r <= in_stream.integral_hold;
    end
    if (en2 && v1_r) begin
      beat2_r.err <= err1_r;
      beat2_r.diff <= diff_nxt;
      beat2_r.integ <= integral_sum_nxt;
    end
  end

  assign mid_valid = v2_r;
  assign mid_beat = beat2_r;

endmodule

// File: design/pvr_mac.sv
// ----------------------------------------------------------------------------
// pvr_mac
// Three gain products, then the sum, floor shift and 32-bit saturation.
// ----------------------------------------------------------------------------
module pvr_mac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pvr_pkg::cfg_t        cfg,
  input  logic                 mid_valid,
  output logic                 mid_ready,
  input  pvr_pkg::mid_beat_t   mid_beat,
  pvr_out_if.source            out_stream
);

  localparam int unsigned PW_P = pvr_pkg::ErrW + pvr_pkg::GainW + 1;
  localparam int unsigned PW_I = pvr_pkg::ValueW + pvr_pkg::GainW + 1;
  localparam int unsigned PW_D = pvr_pkg::DiffW + pvr_pkg::GainW + 1;
  localparam int unsigned SumW = PW_D + 2;
  localparam int unsigned ShW  = SumW - pvr_pkg::FracBits;

  localparam logic signed [pvr_pkg::ValueW-1:0] DriveMax = {1'b0, {31{1'b1}}};
  localparam logic signed [pvr_pkg::ValueW-1:0] DriveMin = {1'b1, {31{1'b0}}};

  logic                          v3_r;
  logic signed [PW_P-1:0]        prod_p_r;
  logic signed [PW_I-1:0]        prod_i_r;
  logic signed [PW_D-1:0]        prod_d_r;
  logic                          vo_r;
  logic signed [pvr_pkg::ValueW-1:0] drive_r;

  logic                          en3;
  logic                          en4;
  logic signed [PW_P-1:0]        prod_p_nxt;
  logic signed [PW_I-1:0]        prod_i_nxt;
  logic signed [PW_D-1:0]        prod_d_nxt;
  logic signed [SumW-1:0]        sum;
  logic signed [ShW-1:0]         shifted;
  logic signed [pvr_pkg::ValueW-1:0] drive_nxt;

  assign en4 = !vo_r || out_stream.ready;
  assign en3 = !v3_r || en4;
  assign mid_ready = en3;

  assign prod_p_nxt = mid_beat.err   * $signed({1'b0, cfg.kp});
  assign prod_i_nxt = mid_beat.integ * $signed({1'b0, cfg.ki});
  assign prod_d_nxt = mid_beat.diff  * $signed({1'b0, cfg.kd});

  always_comb begin
    sum = SumW'(prod_p_r) + SumW'(prod_i_r) + SumW'(prod_d_r);
    // Dropping the fraction bits of a two's complement value rounds down.
    shifted = sum[SumW-1:pvr_pkg::FracBits];
    if (shifted[ShW-1:pvr_pkg::ValueW-1] != {(ShW-pvr_pkg::ValueW+1){shifted[ShW-1]}})
    begin
      drive_nxt = shifted[ShW-1] ? DriveMin : DriveMax;
    end else begin
      drive_nxt = shifted[pvr_pkg::ValueW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en3) begin
        v3_r <= mid_valid;
      end
      if (en4) begin
        vo_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && mid_valid) begin
      prod_p_r <= prod_p_nxt;
      prod_i_r <= prod_i_nxt;
      prod_d_r <= prod_d_nxt;
    end
    if (en4 && v3_r) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_stream.valid = vo_r;
  assign out_stream.drive_value = drive_r;

endmodule
